FILE: src/sellmeier_refractive_index_core_defines.svh
// Assertion macros for the Sellmeier refractive index core checker.
// No dependencies; included by files that assert.
`ifndef SELLMEIER_REFRACTIVE_INDEX_CORE_DEFINES_SVH
`define SELLMEIER_REFRACTIVE_INDEX_CORE_DEFINES_SVH
// Check a property on every clock, held off during reset.
`define SRI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check a property on every clock, reset included.
`define SRI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

FILE: src/sri_pkg.sv
// Shared types and constants of the Sellmeier refractive index core.
// No dependencies.
`default_nettype none
package sri_pkg;
  // Register indexes
  localparam logic [2:0] CFG_B1 = 3'd0;
  localparam logic [2:0] CFG_B2 = 3'd1;
  localparam logic [2:0] CFG_B3 = 3'd2;
  localparam logic [2:0] CFG_C1 = 3'd3;
  localparam logic [2:0] CFG_C2 = 3'd4;
  localparam logic [2:0] CFG_C3 = 3'd5;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_BAD_WL = 3'd1,
    ST_RESON  = 3'd2,
    ST_NONPOS = 3'd3,
    ST_SAT    = 3'd4
  } status_t;

  localparam int TERMS      = 3;
  localparam int LSQ_M_W    = 42;   // w^2 * 2^10 + folded half, below 2^42
  localparam int LSQ_STAGES = 3;    // squared wavelength conversion pipe
  localparam int LSQ_W      = 39;   // squared wavelength, Q.24
  localparam int MD_W       = 39;   // denominator magnitude
  localparam int TERM_W     = 64;   // term numerator and quotient
  localparam int ROOT_W     = 32;
  // 10^6 = 2^6 * 15625: the 2^6 folds into the scale, the rest is a
  // reciprocal multiply by ceil(2^56 / 15625), exact for operands below 2^42
  localparam logic [LSQ_M_W-1:0] UM_HALF     = 42'd7812;
  localparam logic [10:0]        UM_RECIP_HI = 11'h431;
  localparam logic [31:0]        UM_RECIP_LO = 32'hBDE8_2D7C;
  localparam logic [63:0] ONE_Q28 = 64'h0000_0000_1000_0000;
  localparam logic [31:0] MAX_N   = 32'hFFFF_FFFF;
  localparam int LATENCY = 1 + LSQ_STAGES + 1 + TERM_W + 1 + 1 + ROOT_W + 1;

  typedef struct packed {
    logic valid;
    logic wzero;
  } ctl_a_t;

  typedef struct packed {
    logic             valid;
    logic             wzero;
    logic             dz;
    logic [TERMS-1:0] neg;
  } ctl_b_t;

  typedef struct packed {
    logic    valid;
    status_t status;
  } ctl_c_t;
endpackage
`default_nettype wire

FILE: src/sellmeier_refractive_index_core.sv
// Top level of the three-term Sellmeier refractive index core.
// Uses sri_pkg, sri_delay, sri_divider and sri_isqrt.
//
// Usage:
//  - Input: an item is taken at a clock edge with start high and busy low.
//    busy is low whenever the block is out of reset, so one wavelength
//    (unsigned Q12.4 nm) can be given every cycle.
//  - Output: out_valid strobes for one cycle with out_refractive_index
//    (Q4.28) and out_status. The receiver cannot stall; results simply flow.
//  - Pipeline: 3 stages for the nm-to-um squared conversion (reciprocal
//    multiply), 64 stages for the term dividers, 32 for the square root,
//    plus five register stages around them.
//  - Throughput: one item per cycle.
//  - Config: cfg_wr_en writes cfg_data to register cfg_index (B1..B3, then
//    C1..C3); other indexes are ignored. Write only while no item is in flight.
//  - Reset: synchronous, active low; clears the coefficients and all
//    in-flight items, and busy is high while reset is held.
`default_nettype none
module sellmeier_refractive_index_core #(
  parameter int TERM_COUNT = 3
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] in_wavelength_nm,
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output logic             out_valid,
  output logic [31:0]      out_refractive_index,
  output logic [2:0]       out_status
);
  localparam int NT = sri_pkg::TERMS;

  logic [31:0] coef_b_r [NT];
  logic [31:0] coef_c_r [NT];

  // Coefficient registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NT; i++) begin
        coef_b_r[i] <= '0;
        coef_c_r[i] <= '0;
      end
    end else if (cfg_wr_en) begin
      case (cfg_index)
        sri_pkg::CFG_B1: coef_b_r[0] <= cfg_data;
        sri_pkg::CFG_B2: coef_b_r[1] <= cfg_data;
        sri_pkg::CFG_B3: coef_b_r[2] <= cfg_data;
        sri_pkg::CFG_C1: coef_c_r[0] <= cfg_data;
        sri_pkg::CFG_C2: coef_c_r[1] <= cfg_data;
        sri_pkg::CFG_C3: coef_c_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = !rst_n;

  // Stage 1: capture the wavelength
  logic        v1_r;
  logic [15:0] w1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= start && !busy;
    w1_r <= in_wavelength_nm;
  end

  // Squared wavelength in um^2, Q.24, rounded: scale w^2 and add the half
  logic [31:0]                   wsq;
  logic [sri_pkg::LSQ_M_W-1:0]   lsq_m_r;
  logic [63:0]                   pp_ll_r;
  logic [42:0]                   pp_lh_r;
  logic [41:0]                   pp_hl_r;
  logic [20:0]                   pp_hh_r;
  logic [85:0]                   lsq_p;
  logic [sri_pkg::LSQ_W-1:0]     lsq_r;
  assign wsq = w1_r * w1_r;

  // Multiply by the reciprocal in four partial products, then sum and shift
  assign lsq_p = {22'd0, pp_ll_r} + {11'd0, pp_lh_r, 32'd0} + {12'd0, pp_hl_r, 32'd0}
               + {1'b0, pp_hh_r, 64'd0};

  always_ff @(posedge clk) begin
    lsq_m_r <= {wsq, 10'd0} + sri_pkg::UM_HALF;
    pp_ll_r <= lsq_m_r[31:0] * sri_pkg::UM_RECIP_LO;
    pp_lh_r <= lsq_m_r[31:0] * sri_pkg::UM_RECIP_HI;
    pp_hl_r <= lsq_m_r[41:32] * sri_pkg::UM_RECIP_LO;
    pp_hh_r <= lsq_m_r[41:32] * sri_pkg::UM_RECIP_HI;
    lsq_r   <= {9'd0, lsq_p[85:56]};
  end

  sri_pkg::ctl_a_t ctl_a_in, ctl_a_out;
  assign ctl_a_in.valid = v1_r;
  assign ctl_a_in.wzero = (w1_r == 16'd0);

  sri_delay #(.W($bits(sri_pkg::ctl_a_t)), .DEPTH(sri_pkg::LSQ_STAGES)) u_dly_a (
    .clk (clk), .rst_n (rst_n), .d (ctl_a_in), .q (ctl_a_out)
  );

  logic [sri_pkg::LSQ_W-1:0] lsq;
  assign lsq = lsq_r;

  // Stage A: denominators and partial products per term
  sri_pkg::ctl_b_t ctl_b_in, ctl_b_out;
  logic            va_r, wza_r;
  logic [NT-1:0]   dz_r, neg_r;
  logic [63:0]     q_term [NT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r  <= 1'b0;
      wza_r <= 1'b0;
    end else begin
      va_r  <= ctl_a_out.valid;
      wza_r <= ctl_a_out.wzero;
    end
  end

  for (genvar t = 0; t < NT; t++) begin : g_term
    if (t < TERM_COUNT) begin : g_used
      logic signed [40:0]        d;
      logic [sri_pkg::MD_W-1:0]  md;
      logic [31:0]               mb;
      logic [63:0]               pl_r;
      logic [38:0]               ph_r;
      logic [sri_pkg::MD_W-1:0]  md_r;
      logic [63:0]               num;
      assign d  = $signed({2'b00, lsq}) - $signed({9'd0, coef_c_r[t]});
      assign md = d[40] ? sri_pkg::MD_W'(-d) : d[sri_pkg::MD_W-1:0];
      assign mb = coef_b_r[t][31] ? 32'(-coef_b_r[t]) : coef_b_r[t];
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          dz_r[t]  <= 1'b0;
          neg_r[t] <= 1'b0;
        end else begin
          dz_r[t]  <= (d == 41'sd0);
          neg_r[t] <= coef_b_r[t][31] ^ d[40];
        end
        pl_r <= mb * lsq[31:0];
        ph_r <= mb * lsq[sri_pkg::LSQ_W-1:32];
        md_r <= md;
      end
      // Rounded numerator, wrapping at 64 bits
      assign num = pl_r + {ph_r[31:0], 32'd0} + {25'd0, md_r >> 1};
      sri_divider #(.NUM_W(sri_pkg::TERM_W), .DEN_W(sri_pkg::MD_W)) u_div (
        .clk (clk), .num (num), .den (md_r), .quo (q_term[t])
      );
    end else begin : g_unused
      assign dz_r[t]   = 1'b0;
      assign neg_r[t]  = 1'b0;
      assign q_term[t] = '0;
    end
  end

  assign ctl_b_in.valid = va_r;
  assign ctl_b_in.wzero = wza_r;
  assign ctl_b_in.dz    = |dz_r;
  assign ctl_b_in.neg   = neg_r;

  sri_delay #(.W($bits(sri_pkg::ctl_b_t)), .DEPTH(sri_pkg::TERM_W)) u_dly_b (
    .clk (clk), .rst_n (rst_n), .d (ctl_b_in), .q (ctl_b_out)
  );

  // Stage C: apply term signs
  logic [63:0]     sq_r [NT];
  sri_pkg::ctl_b_t ctl_c_r;
  always_ff @(posedge clk) begin
    if (!rst_n) ctl_c_r <= '0;
    else        ctl_c_r <= ctl_b_out;
    for (int i = 0; i < NT; i++) begin
      sq_r[i] <= ctl_b_out.neg[i] ? 64'(-q_term[i]) : q_term[i];
    end
  end

  // Stage D: n squared and pre-status
  logic [63:0]     nsq;
  logic [63:0]     nsq_r;
  sri_pkg::ctl_c_t ctl_d_nxt, ctl_d_r;
  assign nsq = sri_pkg::ONE_Q28 + sq_r[0] + sq_r[1] + sq_r[2];

  always_comb begin
    ctl_d_nxt.valid = ctl_c_r.valid;
    if (ctl_c_r.wzero)                       ctl_d_nxt.status = sri_pkg::ST_BAD_WL;
    else if (ctl_c_r.dz)                     ctl_d_nxt.status = sri_pkg::ST_RESON;
    else if (nsq[63] || nsq == 64'd0)        ctl_d_nxt.status = sri_pkg::ST_NONPOS;
    else if (|nsq[62:36])                    ctl_d_nxt.status = sri_pkg::ST_SAT;
    else                                     ctl_d_nxt.status = sri_pkg::ST_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ctl_d_r <= '0;
    else        ctl_d_r <= ctl_d_nxt;
    nsq_r <= nsq;
  end

  // Square root of n^2 * 2^56
  logic [sri_pkg::ROOT_W-1:0] root;
  logic [sri_pkg::ROOT_W:0]   rem;
  sri_isqrt #(.RW(sri_pkg::ROOT_W)) u_sqrt (
    .x    ({nsq_r[35:0], 28'd0}),
    .clk  (clk),
    .root (root),
    .rem  (rem)
  );

  sri_pkg::ctl_c_t ctl_e;
  sri_delay #(.W($bits(sri_pkg::ctl_c_t)), .DEPTH(sri_pkg::ROOT_W)) u_dly_c (
    .clk (clk), .rst_n (rst_n), .d (ctl_d_r), .q (ctl_e)
  );

  // Round to nearest, saturate and register the result
  logic [32:0] r_rnd;
  assign r_rnd = {1'b0, root} + 33'(rem > {1'b0, root});

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= ctl_e.valid;
    case (ctl_e.status)
      sri_pkg::ST_OK: begin
        if (r_rnd[32]) begin
          out_refractive_index <= sri_pkg::MAX_N;
          out_status           <= sri_pkg::ST_SAT;
        end else begin
          out_refractive_index <= r_rnd[31:0];
          out_status           <= sri_pkg::ST_OK;
        end
      end
      sri_pkg::ST_SAT: begin
        out_refractive_index <= sri_pkg::MAX_N;
        out_status           <= sri_pkg::ST_SAT;
      end
      default: begin
        out_refractive_index <= '0;
        out_status           <= ctl_e.status;
      end
    endcase
  end
endmodule
`default_nettype wire

FILE: src/sri_delay.sv
// Control delay line that keeps flags in step with the arithmetic pipes.
// No dependencies.
`default_nettype none
module sri_delay #(
  parameter int W     = 2,
  parameter int DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic [W-1:0] d,
  output logic      [W-1:0] q
);
  logic [W-1:0] tap_r [DEPTH];

  // Shift every cycle; clear on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) tap_r[i] <= '0;
    end else begin
      tap_r[0] <= d;
      for (int i = 1; i < DEPTH; i++) tap_r[i] <= tap_r[i-1];
    end
  end

  assign q = tap_r[DEPTH-1];
endmodule
`default_nettype wire

FILE: src/sri_divider.sv
// Pipelined restoring divider, one quotient bit per stage.
// No dependencies.
`default_nettype none
module sri_divider #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 39
) (
  input  wire logic             clk,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic      [NUM_W-1:0] quo
);
  logic [DEN_W-1:0] rem_r [NUM_W];
  logic [NUM_W-1:0] nq_r  [NUM_W];
  logic [DEN_W-1:0] den_r [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [NUM_W-1:0] nq_in;
    logic [DEN_W-1:0] den_in;
    logic [DEN_W:0]   trial;
    logic             ge;
    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = num;
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign nq_in  = nq_r[k-1];
      assign den_in = den_r[k-1];
    end
    // Bring down the next numerator bit and try a subtract
    assign trial = {rem_in, nq_in[NUM_W-1]};
    assign ge    = trial >= {1'b0, den_in};
    always_ff @(posedge clk) begin
      rem_r[k] <= ge ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
      nq_r[k]  <= {nq_in[NUM_W-2:0], ge};
      den_r[k] <= den_in;
    end
  end

  assign quo = nq_r[NUM_W-1];
endmodule
`default_nettype wire

FILE: src/sri_isqrt.sv
// Pipelined integer square root, one root bit per stage.
// No dependencies.
`default_nettype none
module sri_isqrt #(
  parameter int RW = 32
) (
  input  wire logic [2*RW-1:0] x,
  input  wire logic            clk,
  output logic      [RW-1:0]   root,
  output logic      [RW:0]     rem
);
  localparam int REM_W = RW + 2;

  logic [REM_W-1:0] rem_r  [RW];
  logic [RW-1:0]    root_r [RW];
  logic [2*RW-1:0]  xs_r   [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [REM_W-1:0] rem_in;
    logic [RW-1:0]    root_in;
    logic [2*RW-1:0]  xs_in;
    logic [REM_W-1:0] shifted;
    logic [REM_W-1:0] trial;
    logic             ge;
    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign xs_in   = x;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign xs_in   = xs_r[k-1];
    end
    // Bring down two radicand bits, try root*4+1
    assign shifted = {rem_in[RW-1:0], xs_in[2*RW-1 -: 2]};
    assign trial   = {root_in, 2'b01};
    assign ge      = shifted >= trial;
    always_ff @(posedge clk) begin
      rem_r[k]  <= ge ? REM_W'(shifted - trial) : shifted;
      root_r[k] <= {root_in[RW-2:0], ge};
      xs_r[k]   <= {xs_in[2*RW-3:0], 2'b00};
    end
  end

  assign root = root_r[RW-1];
  assign rem  = rem_r[RW-1][RW:0];
endmodule
`default_nettype wire

FILE: src/sri_checker.sv
// Port-level checker for the Sellmeier refractive index core, with bind.
// Uses sri_pkg and sellmeier_refractive_index_core_defines.svh.
`default_nettype none
`include "sellmeier_refractive_index_core_defines.svh"
module sri_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic [31:0] out_refractive_index,
  input wire logic [2:0]  out_status
);
  // Every result comes from an item taken earlier
  `SRI_ASSERT(a_result_has_item, out_valid |-> $past(start && !busy, sri_pkg::LATENCY), "result without item")
  // Every item yields a result
  `SRI_ASSERT(a_item_has_result, (start && !busy) |-> ##(sri_pkg::LATENCY) out_valid, "item lost")
  // Error results carry a zero index
  `SRI_ASSERT(a_err_zero, (out_valid && (out_status == sri_pkg::ST_BAD_WL || out_status == sri_pkg::ST_RESON || out_status == sri_pkg::ST_NONPOS)) |-> (out_refractive_index == 32'd0), "error index not zero")
  // Saturated results are pinned at full scale, good ones are nonzero
  `SRI_ASSERT(a_sat_max, (out_valid && out_status == sri_pkg::ST_SAT) |-> (out_refractive_index == sri_pkg::MAX_N), "saturated index not max")
  `SRI_ASSERT_ALWAYS(a_ok_nonzero, (out_valid && out_status == sri_pkg::ST_OK) |-> (out_refractive_index != 32'd0), "ok index zero")
endmodule

bind sellmeier_refractive_index_core sri_checker u_sri_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .start                (start),
  .busy                 (busy),
  .out_valid            (out_valid),
  .out_refractive_index (out_refractive_index),
  .out_status           (out_status)
);
`default_nettype wire

FILE: tb/sellmeier_refractive_index_core_tb.sv
// Self-checking testbench for the Sellmeier refractive index core.
// Depends on sri_pkg and sellmeier_refractive_index_core; runs stand-alone.
`default_nettype none
module sellmeier_refractive_index_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CFG_UNUSED_LO = 3'd6;
  localparam logic [2:0] CFG_UNUSED_HI = 3'd7;
  localparam int CYCLE_LIMIT = 500000;
  localparam logic [31:0] B_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] B_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [31:0]      index;
    sri_pkg::status_t status;
  } index_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] in_wavelength_nm = '0;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        out_valid;
  logic [31:0] out_refractive_index;
  logic [2:0]  out_status;

  logic [15:0]   wavelength_queue[$];
  index_result_t expected_index[$];
  longint        coef_b_copy[3];
  logic [63:0]   coef_c_copy[3];
  int            idle_pct = 0;
  int            errors = 0;
  int            cycles = 0;

  sellmeier_refractive_index_core #(.TERM_COUNT(3)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_wavelength_nm(in_wavelength_nm),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_refractive_index(out_refractive_index),
    .out_status(out_status)
  );

  always #1 clk = ~clk;

  // Squared wavelength in um^2, Q8.24, rounded half up
  function automatic logic [63:0] lambda_sq(input logic [15:0] w);
    logic [63:0] w64;
    w64 = w;
    return (w64 * w64 * 64'd65536 + 64'd500000) / 64'd1000000;
  endfunction

  // Round-to-nearest square root of a 64-bit value
  function automatic logic [63:0] round_sqrt(input logic [63:0] x);
    logic [127:0] r;
    logic [127:0] trial;
    r = '0;
    for (int i = 32; i >= 0; i--) begin
      trial = r | (128'd1 << i);
      if (trial * trial <= {64'd0, x}) r = trial;
    end
    if ({64'd0, x} - r * r > r) r = r + 1;
    return r[63:0];
  endfunction

  function automatic index_result_t sellmeier_index(input logic [15:0] w);
    index_result_t res;
    logic [63:0] lsq, md, mb, q, x, root;
    longint d, nsq;
    res.index = '0;
    res.status = sri_pkg::ST_OK;
    if (w == 0) begin
      res.status = sri_pkg::ST_BAD_WL;
      return res;
    end
    lsq = lambda_sq(w);
    nsq = longint'(sri_pkg::ONE_Q28);
    for (int i = 0; i < 3; i++) begin
      d = longint'(lsq) - longint'(coef_c_copy[i]);
      if (d == 0) begin
        res.status = sri_pkg::ST_RESON;
        return res;
      end
      md = d < 0 ? -d : d;
      mb = coef_b_copy[i] < 0 ? -coef_b_copy[i] : coef_b_copy[i];
      q = (mb * lsq + md / 2) / md;
      if ((coef_b_copy[i] < 0) != (d < 0)) nsq -= longint'(q);
      else nsq += longint'(q);
    end
    if (nsq <= 0) begin
      res.status = sri_pkg::ST_NONPOS;
      return res;
    end
    if (nsq >= (64'sd1 <<< 36)) begin
      res.index = sri_pkg::MAX_N;
      res.status = sri_pkg::ST_SAT;
      return res;
    end
    x = 64'(nsq) << 28;
    root = round_sqrt(x);
    if (root > {32'd0, sri_pkg::MAX_N}) begin
      res.index = sri_pkg::MAX_N;
      res.status = sri_pkg::ST_SAT;
    end else begin
      res.index = root[31:0];
    end
    return res;
  endfunction

  // Driver: hold an item while busy, otherwise advance or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) expected_index.push_back(sellmeier_index(in_wavelength_nm));
      if (!(start && busy)) begin
        if (wavelength_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
          start <= 1'b1;
          in_wavelength_nm <= wavelength_queue.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    index_result_t exp_r;
    if (rst_n && out_valid) begin
      if (expected_index.size() == 0) begin
        errors++;
        $error("unexpected result index=%h status=%0d", out_refractive_index, out_status);
      end else begin
        exp_r = expected_index.pop_front();
        if (out_refractive_index !== exp_r.index) begin
          errors++;
          $error("refractive_index: expected %h, got %h", exp_r.index, out_refractive_index);
        end
        if (out_status !== exp_r.status) begin
          errors++;
          $error("status: expected %0d, got %0d", exp_r.status, out_status);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("sellmeier_refractive_index_core regression: fail");
      $finish;
    end
  end

  // Write all six coefficients plus one unused index, then drop the enable
  task automatic load_coefs(input logic [31:0] b1, b2, b3, c1, c2, c3);
    logic [31:0] vals[6];
    logic [2:0]  regs[6];
    vals = '{b1, b2, b3, c1, c2, c3};
    regs = '{sri_pkg::CFG_B1, sri_pkg::CFG_B2, sri_pkg::CFG_B3,
             sri_pkg::CFG_C1, sri_pkg::CFG_C2, sri_pkg::CFG_C3};
    for (int i = 0; i < 6; i++) begin
      @(posedge clk);
      cfg_wr_en <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      if (i < 3) coef_b_copy[i] = longint'(signed'(vals[i]));
      else coef_c_copy[i-3] = {32'd0, vals[i]};
    end
    @(posedge clk);
    cfg_index <= $urandom_range(1) ? CFG_UNUSED_LO : CFG_UNUSED_HI;
    cfg_data <= $urandom;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Wait until every item is accepted and answered, then let the pipe settle
  task automatic drain();
    while (wavelength_queue.size() > 0 || start || expected_index.size() > 0)
      @(posedge clk);
    repeat (sri_pkg::LATENCY + 10) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_b(input int mode);
    case (mode)
      0: return $urandom_range(1) ? $urandom_range(32'h2000_0000) : -$urandom_range(32'h0800_0000);
      1: return $urandom;
      default: begin
        case ($urandom_range(3))
          0: return B_MAX;
          1: return B_MIN;
          2: return 32'd0;
          default: return 32'd1;
        endcase
      end
    endcase
  endfunction

  function automatic logic [31:0] rand_c(input int mode);
    case (mode)
      0: return $urandom_range(32'h0400_0000);
      1: return $urandom;
      default: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
    endcase
  endfunction

  initial begin
    logic [31:0] bk_b1, bk_b2, bk_b3, bk_c1, bk_c2, bk_c3, cr[3];
    logic [15:0] res_w, w;
    int mode;
    int idle_set[4];
    idle_set = '{0, 70, 10, 35};
    for (int i = 0; i < 3; i++) begin
      coef_b_copy[i] = 0;
      coef_c_copy[i] = 0;
    end
    bk_b1 = $rtoi(1.03961212 * 2.0 ** 28);
    bk_b2 = $rtoi(0.231792344 * 2.0 ** 28);
    bk_b3 = $rtoi(1.01046945 * 2.0 ** 28);
    bk_c1 = $rtoi(0.00600069867 * 2.0 ** 24);
    bk_c2 = $rtoi(0.0200179144 * 2.0 ** 24);
    bk_c3 = $rtoi(103.560653 * 2.0 ** 24);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Reset coefficients: tiny wavelength hits resonance with c = 0
    wavelength_queue = '{16'd0, 16'd1, 16'd16, 16'hFFFF};
    drain();

    // Glass-like dispersion, field extremes
    load_coefs(bk_b1, bk_b2, bk_b3, bk_c1, bk_c2, bk_c3);
    wavelength_queue = '{16'd0, 16'd1, 16'hFFFF, 16'h8000, 16'd9400, 16'h7FFF, 16'd3200};
    drain();

    // Resonance where the second pole equals the squared wavelength
    load_coefs(bk_b1, bk_b2, bk_b3, bk_c1, 32'(lambda_sq(16'd16000)), bk_c3);
    wavelength_queue = '{16'd16000, 16'd15999, 16'd16001};
    drain();

    // Largest B with zero C; most negative B gives a nonpositive square
    load_coefs(B_MAX, B_MAX, B_MAX, 32'd0, 32'd0, 32'd0);
    wavelength_queue = '{16'd100, 16'hFFFF, 16'd8000};
    drain();
    load_coefs(B_MIN, B_MIN, B_MIN, 32'd0, 32'd0, 32'd0);
    wavelength_queue = '{16'd100, 16'hFFFF};
    drain();

    // Pole just under the wavelength saturates; largest C everywhere
    load_coefs(B_MAX, 32'd0, 32'd0, 32'(lambda_sq(16'd8000) - 64'd1), 32'd0, 32'd0);
    wavelength_queue = '{16'd8000, 16'd8001};
    drain();
    load_coefs(B_MAX, B_MIN, B_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wavelength_queue = '{16'd1, 16'hFFFF, 16'd20000};
    drain();

    // Random phases with varying sender idling
    for (int p = 0; p < 8; p++) begin
      idle_pct = idle_set[p % 4];
      mode = $urandom_range(3);
      res_w = 16'($urandom_range(16'hFFFF, 1));
      if (mode == 3) begin
        cr = '{bk_c1, bk_c2, bk_c3};
        cr[$urandom_range(2)] = 32'(lambda_sq(res_w));
        load_coefs(bk_b1 + $urandom_range(32'h0100_0000), bk_b2, bk_b3, cr[0], cr[1], cr[2]);
      end else begin
        load_coefs(rand_b(mode), rand_b(mode), rand_b(mode),
                   rand_c(mode), rand_c(mode), rand_c(mode));
      end
      for (int i = 0; i < 180; i++) begin
        case ($urandom_range(19))
          0: w = 16'd0;
          1: w = res_w;
          2, 3, 4, 5, 6: w = 16'($urandom);
          default: w = 16'($urandom_range(16'd48000, 16'd3200));
        endcase
        wavelength_queue.push_back(w);
      end
      drain();
    end

    if (errors == 0) begin
      $display("sellmeier_refractive_index_core regression: pass");
    end else begin
      $display("sellmeier_refractive_index_core regression: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
